[design/rlps_pkg.sv]
// shared types, constants and microcode table for the pursuit steering block
package rlps_pkg;

  // fixed field geometry
  localparam int ANGLE_BITS = 16;
  localparam int POS_BITS   = 32;

  // cordic datapath widths
  localparam int DW = 54;
  localparam int ZW = 34;

  localparam int ATAN_IDX_W = 5;
  localparam int PC_W       = 4;
  localparam int OP_W       = 4;
  localparam int COND_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [29:0]   KINV_Q30  = 30'd652032875;
  localparam logic [DW-1:0] NORM_LIM8 = DW'(1) << 41;
  localparam logic [DW-1:0] NORM_LIM  = DW'(1) << 49;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 4'd2;
  localparam logic [OP_W-1:0] OP_NORM8   = 4'd3;
  localparam logic [OP_W-1:0] OP_NORM1   = 4'd4;
  localparam logic [OP_W-1:0] OP_VEC     = 4'd5;
  localparam logic [OP_W-1:0] OP_STEER   = 4'd6;
  localparam logic [OP_W-1:0] OP_ROTLOAD = 4'd7;
  localparam logic [OP_W-1:0] OP_ROT     = 4'd8;
  localparam logic [OP_W-1:0] OP_ROUND   = 4'd9;
  localparam logic [OP_W-1:0] OP_MOVE    = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT     = 4'd11;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NO_BEAT  = 4'd2;
  localparam logic [COND_W-1:0] C_RESTART  = 4'd3;
  localparam logic [COND_W-1:0] C_ZERO     = 4'd4;
  localparam logic [COND_W-1:0] C_SMALL8   = 4'd5;
  localparam logic [COND_W-1:0] C_SMALL1   = 4'd6;
  localparam logic [COND_W-1:0] C_NOT_LAST = 4'd7;
  localparam logic [COND_W-1:0] C_OUT_FREE = 4'd8;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_RST   = 4'd1;
  localparam logic [PC_W-1:0] PC_ZCHK  = 4'd2;
  localparam logic [PC_W-1:0] PC_NORM8 = 4'd3;
  localparam logic [PC_W-1:0] PC_NORM1 = 4'd4;
  localparam logic [PC_W-1:0] PC_VEC   = 4'd5;
  localparam logic [PC_W-1:0] PC_STEER = 4'd6;
  localparam logic [PC_W-1:0] PC_ROTLD = 4'd7;
  localparam logic [PC_W-1:0] PC_ROT   = 4'd8;
  localparam logic [PC_W-1:0] PC_ROUND = 4'd9;
  localparam logic [PC_W-1:0] PC_MOVE  = 4'd10;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd11;
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   tgt;
  } ctrl_word_t;

  // arctangent of 2^-i, full turn = 2^32
  function automatic logic [31:0] atan_at(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // microcode: jump to tgt when cond holds, else fall through
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE:  w = '{OP_LOAD,    C_NO_BEAT,  PC_IDLE};
      PC_RST:   w = '{OP_RESTART, C_RESTART,  PC_OUT};
      PC_ZCHK:  w = '{OP_NOP,     C_ZERO,     PC_STEER};
      PC_NORM8: w = '{OP_NORM8,   C_SMALL8,   PC_NORM8};
      PC_NORM1: w = '{OP_NORM1,   C_SMALL1,   PC_NORM1};
      PC_VEC:   w = '{OP_VEC,     C_NOT_LAST, PC_VEC};
      PC_STEER: w = '{OP_STEER,   C_NEVER,    PC_IDLE};
      PC_ROTLD: w = '{OP_ROTLOAD, C_NEVER,    PC_IDLE};
      PC_ROT:   w = '{OP_ROT,     C_NOT_LAST, PC_ROT};
      PC_ROUND: w = '{OP_ROUND,   C_NEVER,    PC_IDLE};
      PC_MOVE:  w = '{OP_MOVE,    C_NEVER,    PC_IDLE};
      PC_OUT:   w = '{OP_OUT,     C_OUT_FREE, PC_IDLE};
      PC_WAIT:  w = '{OP_NOP,     C_ALWAYS,   PC_OUT};
      default:  w = '{OP_NOP,     C_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  // clamp a widened sum back to the signed position range
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [POS_BITS+1:0] v);
    logic signed [POS_BITS-1:0] r;
    if (!v[POS_BITS+1] && (v[POS_BITS:POS_BITS-1] != 2'b00)) begin
      r = {1'b0, {(POS_BITS-1){1'b1}}};
    end else if (v[POS_BITS+1] && (v[POS_BITS:POS_BITS-1] != 2'b11)) begin
      r = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[design/rate_limited_pursuit_steering_top.sv]
// pursuit steering: microcoded cordic sequencer for bearing, turn and move
// a new beat is taken in the cycle the result turns valid, but none while the block works
//   on the last one or while an output stall holds it; one shared cordic stage serves both
//   the vectoring and the rotation pass, and restart or zero offset beats skip passes
// reset: position (0, 5.0), heading quarter turn, registers to their defaults
module rate_limited_pursuit_steering_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // target_x[31:0], target_z[63:32]
  input  logic        s_axis_tuser_i,   // restart
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // pos_x, pos_z, heading, bearing (low to high)
  output logic        m_axis_tuser_o    // aligned
);

  localparam int DW    = rlps_pkg::DW;
  localparam int ZW    = rlps_pkg::ZW;
  localparam int PB    = rlps_pkg::POS_BITS;
  localparam int AB    = rlps_pkg::ANGLE_BITS;
  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

  // sequencer
  logic [rlps_pkg::PC_W-1:0] pc_q, pc_d;
  rlps_pkg::ctrl_word_t      cw;
  logic                      cond_hit;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  // config registers
  logic [14:0]          turn_step_q;
  logic [20:0]          move_step_q;
  logic signed [PB-1:0] start_x_q, start_z_q;
  logic [AB-1:0]        start_heading_q;

  // architectural state
  logic signed [PB-1:0] pos_x_q, pos_x_d, pos_z_q, pos_z_d;
  logic [AB-1:0]        heading_q, heading_d;

  // cordic working registers: x, y and the angle accumulator
  logic signed [DW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic restart_q, restart_d, zero_q, zero_d, flip_q, flip_d;
  logic [AB-1:0] bearing_q, bearing_d;
  logic          aligned_q, aligned_d;

  // output register
  logic          out_valid_q;
  logic [95:0]   out_data_q;
  logic          out_user_q;
  logic          out_free;
  logic          in_beat;

  // datapath helpers
  logic signed [PB:0]   tx, tz, dx, dz;
  logic [DW-1:0]        ax, ay;
  logic                 small8, small1, last;
  logic signed [DW-1:0] sh_x, sh_y;
  logic signed [ZW-1:0] tab;
  logic                 d_pos;
  logic [31:0]          ang_rnd;
  logic [AB-1:0]        bear_w, err;
  logic signed [AB:0]   err_s, ts_s;
  logic signed [ZW-1:0] za;
  logic [50:0]          mul_w;
  logic signed [DW-1:0] rx, ry;
  logic signed [PB+1:0] sum_x, sum_z;

  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (pc_q == rlps_pkg::PC_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  assign cw   = rlps_pkg::ucode_rom(pc_q);
  assign last = (cnt_q == CNT_LAST);

  // magnitudes for the normalize loop
  assign ax     = x_q[DW-1] ? DW'(-x_q) : DW'(x_q);
  assign ay     = y_q[DW-1] ? DW'(-y_q) : DW'(y_q);
  assign small8 = (ax < rlps_pkg::NORM_LIM8) && (ay < rlps_pkg::NORM_LIM8);
  assign small1 = (ax < rlps_pkg::NORM_LIM) && (ay < rlps_pkg::NORM_LIM);

  // offset to target, one bit wider than a position
  assign tx = $signed({s_axis_tdata_i[31], s_axis_tdata_i[31:0]});
  assign tz = $signed({s_axis_tdata_i[63], s_axis_tdata_i[63:32]});
  assign dx = tx - $signed({pos_x_q[PB-1], pos_x_q});
  assign dz = tz - $signed({pos_z_q[PB-1], pos_z_q});

  // shared cordic micro-rotation
  assign sh_x  = x_q >>> cnt_q;
  assign sh_y  = y_q >>> cnt_q;
  assign tab   = $signed({2'b00, rlps_pkg::atan_at(rlps_pkg::ATAN_IDX_W'(cnt_q))});
  assign d_pos = (cw.op == rlps_pkg::OP_ROT) ? z_q[ZW-1] : !y_q[DW-1];

  // steering: round the bearing and wrap the error to a signed half turn
  assign ang_rnd = z_q[31:0] + 32'h0000_8000;
  assign bear_w  = ang_rnd[31:32-AB];
  assign err     = bear_w - heading_q;
  assign err_s   = $signed({err[AB-1], err});
  assign ts_s    = $signed({2'b00, turn_step_q});

  // rotation start: heading as signed 32-bit angle, gain-corrected radius
  assign za    = ZW'($signed({heading_q, 16'h0000}));
  assign mul_w = 51'(move_step_q) * 51'(rlps_pkg::KINV_Q30);

  // round the rotated vector half up to Q16.16
  assign rx = (x_q + (DW'(1) <<< 29)) >>> 30;
  assign ry = (y_q + (DW'(1) <<< 29)) >>> 30;

  assign sum_x = $signed({{2{pos_x_q[PB-1]}}, pos_x_q}) + y_q[PB+1:0];
  assign sum_z = $signed({{2{pos_z_q[PB-1]}}, pos_z_q}) + x_q[PB+1:0];

  // jump condition decode
  always_comb begin
    unique case (cw.cond)
      rlps_pkg::C_NEVER:    cond_hit = 1'b0;
      rlps_pkg::C_ALWAYS:   cond_hit = 1'b1;
      rlps_pkg::C_NO_BEAT:  cond_hit = !in_beat;
      rlps_pkg::C_RESTART:  cond_hit = restart_q;
      rlps_pkg::C_ZERO:     cond_hit = zero_q;
      rlps_pkg::C_SMALL8:   cond_hit = small8;
      rlps_pkg::C_SMALL1:   cond_hit = small1;
      rlps_pkg::C_NOT_LAST: cond_hit = !last;
      rlps_pkg::C_OUT_FREE: cond_hit = out_free;
      default:              cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? cw.tgt : pc_q + 1'b1;
  end

  // datapath operations, one per microcode step
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    cnt_d     = '0;
    restart_d = restart_q;
    zero_d    = zero_q;
    flip_d    = flip_q;
    pos_x_d   = pos_x_q;
    pos_z_d   = pos_z_q;
    heading_d = heading_q;
    bearing_d = bearing_q;
    aligned_d = aligned_q;
    case (cw.op) inside
      rlps_pkg::OP_LOAD: begin
        if (in_beat) begin
          restart_d = s_axis_tuser_i;
          zero_d    = (dx == '0) && (dz == '0);
          // fold into the right half plane
          if (dz[PB]) begin
            x_d = -DW'(dz);
            y_d = -DW'(dx);
            z_d = ZW'(34'h0_8000_0000);
          end else begin
            x_d = DW'(dz);
            y_d = DW'(dx);
            z_d = '0;
          end
        end
      end
      rlps_pkg::OP_RESTART: begin
        if (restart_q) begin
          pos_x_d   = start_x_q;
          pos_z_d   = start_z_q;
          heading_d = start_heading_q;
          bearing_d = '0;
          aligned_d = 1'b0;
        end
      end
      rlps_pkg::OP_NORM8: begin
        if (small8) begin
          x_d = x_q <<< 8;
          y_d = y_q <<< 8;
        end
      end
      rlps_pkg::OP_NORM1: begin
        if (small1) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end
      end
      rlps_pkg::OP_VEC, rlps_pkg::OP_ROT: begin
        cnt_d = last ? '0 : cnt_q + 1'b1;
        if (d_pos) begin
          x_d = x_q + sh_y;
          y_d = y_q - sh_x;
          z_d = z_q + tab;
        end else begin
          x_d = x_q - sh_y;
          y_d = y_q + sh_x;
          z_d = z_q - tab;
        end
      end
      rlps_pkg::OP_STEER: begin
        bearing_d = bear_w;
        aligned_d = 1'b0;
        if (err_s >= ts_s) begin
          heading_d = heading_q + AB'(turn_step_q);
        end else if (err_s <= -ts_s) begin
          heading_d = heading_q - AB'(turn_step_q);
        end else begin
          // inside one step: snap onto the bearing
          heading_d = bear_w;
          aligned_d = 1'b1;
        end
      end
      rlps_pkg::OP_ROTLOAD: begin
        x_d = $signed(DW'(mul_w));
        y_d = '0;
        // fold headings beyond a quarter turn by a half turn
        if (za > $signed(ZW'(1) <<< 30)) begin
          z_d    = za - $signed(ZW'(1) <<< 31);
          flip_d = 1'b1;
        end else if (za < -$signed(ZW'(1) <<< 30)) begin
          z_d    = za + $signed(ZW'(1) <<< 31);
          flip_d = 1'b1;
        end else begin
          z_d    = za;
          flip_d = 1'b0;
        end
      end
      rlps_pkg::OP_ROUND: begin
        x_d = flip_q ? -rx : rx;
        y_d = flip_q ? -ry : ry;
      end
      rlps_pkg::OP_MOVE: begin
        // x moves by sin (y component), z by cos (x component)
        pos_x_d = rlps_pkg::sat_pos(sum_x);
        pos_z_d = rlps_pkg::sat_pos(sum_z);
      end
      default: begin
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q            <= rlps_pkg::PC_IDLE;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
      turn_step_q     <= 15'd91;
      move_step_q     <= 21'd1966;
      start_x_q       <= '0;
      start_z_q       <= 32'sd327680;
      start_heading_q <= 16'd16384;
      pos_x_q         <= '0;
      pos_z_q         <= 32'sd327680;
      heading_q       <= 16'd16384;
    end else begin
      pc_q      <= pc_d;
      cnt_q     <= cnt_d;
      pos_x_q   <= pos_x_d;
      pos_z_q   <= pos_z_d;
      heading_q <= heading_d;
      if ((cw.op == rlps_pkg::OP_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rlps_pkg::CFG_TURN_STEP:     turn_step_q     <= cfg_data_i[14:0];
          rlps_pkg::CFG_MOVE_STEP:     move_step_q     <= cfg_data_i[20:0];
          rlps_pkg::CFG_START_X:       start_x_q       <= $signed(cfg_data_i);
          rlps_pkg::CFG_START_Z:       start_z_q       <= $signed(cfg_data_i);
          rlps_pkg::CFG_START_HEADING: start_heading_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    restart_q <= restart_d;
    zero_q    <= zero_d;
    flip_q    <= flip_d;
    bearing_q <= bearing_d;
    aligned_q <= aligned_d;
    if ((cw.op == rlps_pkg::OP_OUT) && out_free) begin
      out_data_q <= {bearing_q, heading_q, pos_z_q, pos_x_q};
      out_user_q <= aligned_q;
    end
  end

  // iteration counter is back at zero whenever the sequencer waits for a beat
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == rlps_pkg::PC_IDLE) |-> (cnt_q == '0))
    else $error("cordic counter not cleared at idle");

  // an accepted beat always moves the sequencer to the restart check
  a_beat_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (pc_q == rlps_pkg::PC_RST))
    else $error("sequencer did not start after input beat");

  // the wait step is only reached while an earlier result is still pending
  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == rlps_pkg::PC_WAIT) |-> out_valid_q)
    else $error("waiting on output with no pending beat");

  // program counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= rlps_pkg::PC_WAIT)
    else $error("program counter out of range");

endmodule

[dv/tb.sv]
// self-checking testbench for the pursuit steering block: stepping predictor and stream checks
typedef struct {
  bit [31:0] pos_x;
  bit [31:0] pos_z;
  bit [15:0] heading;
  bit [15:0] bearing;
  bit        aligned;
} pose_t;

// follower state, register copies and the poses still owed by the block
class pursuit_tracker;
  bit [14:0]        turn_step;
  bit [20:0]        move_step;
  bit signed [31:0] start_x;
  bit signed [31:0] start_z;
  bit [15:0]        start_heading;
  bit signed [31:0] pos_x;
  bit signed [31:0] pos_z;
  bit [15:0]        heading;
  bit [31:0]        arctan[16];
  pose_t            expected_poses[$];
  int               mismatches;

  function new();
    turn_step     = 15'd91;
    move_step     = 21'd1966;
    start_x       = 32'sd0;
    start_z       = 32'sd327680;
    start_heading = 16'h4000;
    pos_x         = 32'sd0;
    pos_z         = 32'sd327680;
    heading       = 16'h4000;
    mismatches    = 0;
    // atan(2^-i), full turn = 2^32
    arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
               32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
               32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
               32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
  endfunction

  function void set_reg(bit [2:0] idx, bit [31:0] val);
    case (idx)
      rlps_pkg::CFG_TURN_STEP:     turn_step = val[14:0];
      rlps_pkg::CFG_MOVE_STEP:     move_step = val[20:0];
      rlps_pkg::CFG_START_X:       start_x = val;
      rlps_pkg::CFG_START_Z:       start_z = val;
      rlps_pkg::CFG_START_HEADING: start_heading = val[15:0];
      default: ;
    endcase
  endfunction

  // vectoring cordic on (dz, dx), +z is bearing zero
  function bit [15:0] bearing_to(longint dx, longint dz);
    longint    cx;
    longint    cy;
    longint    nx;
    bit [31:0] acc;
    if (dx == 0 && dz == 0) return 16'h0000;
    cx  = dz;
    cy  = dx;
    acc = 32'h0;
    if (cx < 0) begin
      cx  = -cx;
      cy  = -cy;
      acc = 32'h8000_0000;
    end
    // scale up until the larger component reaches 2^49
    while ((cx < 0 ? -cx : cx) < (64'sd1 <<< 49) && (cy < 0 ? -cy : cy) < (64'sd1 <<< 49)) begin
      cx = cx * 2;
      cy = cy * 2;
    end
    for (int i = 0; i < 16; i++) begin
      if (cy >= 0) begin
        nx  = cx + (cy >>> i);
        cy  = cy - (cx >>> i);
        acc = acc + arctan[i];
      end else begin
        nx  = cx - (cy >>> i);
        cy  = cy + (cx >>> i);
        acc = acc - arctan[i];
      end
      cx = nx;
    end
    acc = acc + 32'h0000_8000;
    return acc[31:16];
  endfunction

  // rotation cordic: move_step along heading h, x by sin and z by cos
  function void step_along(bit [15:0] h, output longint mx, output longint mz);
    longint rz;
    longint cx;
    longint cy;
    longint nx;
    bit     flip;
    rz   = longint'($signed({h, 16'h0000}));
    flip = 1'b0;
    if (rz > 64'sd1073741824 || rz < -64'sd1073741824) begin
      flip = 1'b1;
      rz   = (rz > 0) ? rz - 64'sd2147483648 : rz + 64'sd2147483648;
    end
    cx = longint'(move_step) * 64'sd652032875;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      if (rz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        rz = rz - longint'(arctan[i]);
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        rz = rz + longint'(arctan[i]);
      end
      cx = nx;
    end
    cx = (cx + 64'sd536870912) >>> 30;
    cy = (cy + 64'sd536870912) >>> 30;
    mx = flip ? -cy : cy;
    mz = flip ? -cx : cx;
  endfunction

  function bit signed [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function void note_target(bit restart, bit [31:0] tx, bit [31:0] tz);
    pose_t     p;
    longint    dx;
    longint    dz;
    longint    err;
    longint    mx;
    longint    mz;
    bit [15:0] diff;
    p.bearing = 16'h0000;
    p.aligned = 1'b0;
    if (restart) begin
      pos_x   = start_x;
      pos_z   = start_z;
      heading = start_heading;
    end else begin
      dx        = longint'($signed(tx)) - longint'(pos_x);
      dz        = longint'($signed(tz)) - longint'(pos_z);
      p.bearing = bearing_to(dx, dz);
      diff      = p.bearing - heading;
      err       = longint'(diff);
      if (err >= 32768) err = err - 65536;
      // turn by at most one step, snap when closer than that
      if (err >= longint'(turn_step)) begin
        heading = heading + turn_step;
      end else if (err <= -longint'(turn_step)) begin
        heading = heading - turn_step;
      end else begin
        heading   = p.bearing;
        p.aligned = 1'b1;
      end
      step_along(heading, mx, mz);
      pos_x = clamp_q16(longint'(pos_x) + mx);
      pos_z = clamp_q16(longint'(pos_z) + mz);
    end
    p.pos_x   = pos_x;
    p.pos_z   = pos_z;
    p.heading = heading;
    expected_poses.push_back(p);
  endfunction

  function void log_mismatch(string what);
    if (mismatches < 10) $display("mismatch %0d: %s", mismatches + 1, what);
    mismatches++;
  endfunction

  function void check_pose(logic [95:0] beat, logic user);
    pose_t want;
    if (expected_poses.size() == 0) begin
      log_mismatch($sformatf("output beat %h/%b with no pose pending", beat, user));
      return;
    end
    want = expected_poses.pop_front();
    if (beat[31:0] !== want.pos_x || beat[63:32] !== want.pos_z ||
        beat[79:64] !== want.heading || beat[95:80] !== want.bearing ||
        user !== want.aligned) begin
      log_mismatch($sformatf(
        "expected/actual x %h/%h z %h/%h heading %h/%h bearing %h/%h aligned %b/%b",
        want.pos_x, beat[31:0], want.pos_z, beat[63:32], want.heading, beat[79:64],
        want.bearing, beat[95:80], want.aligned, user));
    end
  endfunction
endclass

module tb;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // target_x, target_z (low to high)
  logic        s_axis_tuser_i;   // restart
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [95:0] m_axis_tdata_o;   // pos_x, pos_z, heading, bearing (low to high)
  logic        m_axis_tuser_o;   // aligned

  bit             gaps_on = 1'b1;
  int             stuck_cycles = 0;
  pursuit_tracker tracker;

  rate_limited_pursuit_steering_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one beat in, with an occasional idle burst ahead of it
  task automatic send_beat(input bit restart, input bit [31:0] tx, input bit [31:0] tz);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= restart;
    s_axis_tdata_i  <= {tz, tx};
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    tracker.note_target(restart, tx, tz);
  endtask

  // mostly targets near the follower so it turns, snaps and orbits
  task automatic send_random_target();
    bit          restart;
    bit [31:0]   tx;
    bit [31:0]   tz;
    int unsigned pick;
    restart = ($urandom_range(0, 15) == 0);
    pick    = $urandom_range(0, 9);
    tx = tracker.pos_x + ($signed($urandom) >>> $urandom_range(0, 31));
    tz = tracker.pos_z + ($signed($urandom) >>> $urandom_range(0, 31));
    if (pick < 2) begin
      tx = $urandom;
      tz = $urandom;
    end else if (pick == 2) begin
      tx = tracker.pos_x;
    end else if (pick == 3) begin
      tz = tracker.pos_z;
    end
    send_beat(restart, tx, tz);
  endtask

  // stop sending, wait for every pose, then let the block go quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input bit [14:0] ts, input bit [20:0] ms, input bit [31:0] sx,
                              input bit [31:0] sz, input bit [15:0] sh);
    bit [2:0]  idx[5];
    bit [31:0] val[5];
    idx = '{rlps_pkg::CFG_TURN_STEP, rlps_pkg::CFG_MOVE_STEP, rlps_pkg::CFG_START_X,
            rlps_pkg::CFG_START_Z, rlps_pkg::CFG_START_HEADING};
    val = '{32'(ts), 32'(ms), sx, sz, 32'(sh)};
    for (int k = 0; k < 5; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
      tracker.set_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_random_regs();
    bit [14:0] ts;
    bit [20:0] ms;
    bit [31:0] sx;
    bit [31:0] sz;
    bit [15:0] sh;
    case ($urandom_range(0, 3))
      0:       ts = 15'd0;
      1:       ts = 15'h7FFF;
      2:       ts = 15'($urandom_range(0, 32767));
      default: ts = 15'($urandom_range(1, 2048));
    endcase
    case ($urandom_range(0, 3))
      0:       ms = 21'd0;
      1:       ms = 21'h100000;
      2:       ms = 21'($urandom_range(0, 1048576));
      default: ms = 21'($urandom_range(1, 65536));
    endcase
    sx = $urandom;
    sz = $urandom;
    sh = 16'($urandom);
    if ($urandom_range(0, 3) == 0) sx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if ($urandom_range(0, 3) == 0) sz = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if ($urandom_range(0, 5) == 0) sh = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    program_regs(ts, ms, sx, sz, sh);
  endtask

  // result side: ready drops in random bursts while gaps are on
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // output checks and a watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1) begin
      tracker.check_pose(m_axis_tdata_o, m_axis_tuser_o);
    end
    if ((s_axis_tvalid_i && s_axis_tready_o === 1'b1) || cfg_we_i ||
        (m_axis_tvalid_o === 1'b1 && m_axis_tready_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tracker = new();
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= rlps_pkg::CFG_TURN_STEP;
    cfg_data_i      <= 32'h0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 64'h0;
    s_axis_tuser_i  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: zero offset, axis bearings, all quadrants, extremes
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h0, 32'd327680);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'd327680);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h0, 32'h8000_0000);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h8000_0000, 32'd327680);
    send_beat(1'b0, 32'h8000_0000, 32'h8000_0000);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();

    // no turning, move step 16.0 along +x into the positive x limit
    program_regs(15'd0, 21'h100000, 32'h7FFF_0000, 32'h8000_8000, 16'h4000);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h0, 32'h0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    settle();

    // heading a half turn, driven into the negative z limit
    program_regs(15'd0, 21'h100000, 32'h8000_8000, 32'h8000_8000, 16'h8000);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(1'b0, 32'h0, 32'h0);
    settle();

    // widest turn, no motion, start at the corner of the range
    program_regs(15'h7FFF, 21'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_beat(1'b1, 32'h0, 32'h0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(1'b0, 32'h0, 32'h0);
    settle();

    // random settings; the last phase runs without idling
    for (int ph = 0; ph < 9; ph++) begin
      gaps_on = (ph == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
      program_random_regs();
      repeat (70) send_random_target();
      settle();
    end

    if (tracker.mismatches == 0 && tracker.expected_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
